// ----- hdl/orlb_pkg.sv -----
`default_nettype none

package orlb_pkg;

  // Store geometry
  localparam int CAPACITY = 4096;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = 13;
  localparam logic [CNT_W-1:0] CAP_CNT       = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_LAST      = CNT_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] CAP_NO_LINE   = CNT_W'(CAPACITY + 1);

  // Field widths
  localparam int OP_W    = 2;
  localparam int BYTE_W  = 8;
  localparam int LEVEL_W = 3;
  localparam int LIMIT_W = 16;

  localparam logic [BYTE_W-1:0]  NEWLINE_CODE  = 8'h0A;
  localparam logic [LEVEL_W-1:0] LEVEL_DEFAULT = 3'd7;

  // Operation codes on the input channel
  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_BEGIN = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

  // Command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    K_NONE,
    K_STORE,
    K_DROP,
    K_BEGIN,
    K_READ
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [BYTE_W-1:0]   data;
    logic [LIMIT_W-1:0]  limit;
  } entry_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              out_valid;
    logic              out_last;
    logic              push_stored;
    logic [CNT_W-1:0]  stored_count;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/orlb_ram.sv -----
`default_nettype none

module orlb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read, held while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/orlb_front.sv -----
`default_nettype none

module orlb_front (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [orlb_pkg::OP_W-1:0]       in_operation,
  input  wire logic [orlb_pkg::BYTE_W-1:0]     in_data_byte,
  input  wire logic [orlb_pkg::LEVEL_W-1:0]    in_severity,
  input  wire logic [orlb_pkg::LIMIT_W-1:0]    in_dump_limit,
  input  wire logic                            cfg_wr_en,
  input  wire logic [orlb_pkg::LEVEL_W-1:0]    cfg_wr_data,
  output logic                                 q_vld,
  output orlb_pkg::entry_t                     q_entry,
  input  wire logic                            q_pop
);

  logic [orlb_pkg::LEVEL_W-1:0] level_r;
  orlb_pkg::entry_t             slot_r [orlb_pkg::QDEPTH];
  logic [orlb_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [orlb_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [orlb_pkg::QCNT_W-1:0]  fill_r, fill_nxt;
  orlb_pkg::entry_t             cls;
  logic                         take;

  // Threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= orlb_pkg::LEVEL_DEFAULT;
    end else if (cfg_wr_en) begin
      level_r <= cfg_wr_data;
    end
  end

  // Classify the incoming word
  always_comb begin
    cls.data  = in_data_byte;
    cls.limit = in_dump_limit;
    unique case (in_operation)
      orlb_pkg::OP_PUSH: begin
        cls.kind = (in_severity <= level_r) ? orlb_pkg::K_STORE : orlb_pkg::K_DROP;
      end
      orlb_pkg::OP_BEGIN: cls.kind = orlb_pkg::K_BEGIN;
      orlb_pkg::OP_READ:  cls.kind = orlb_pkg::K_READ;
      orlb_pkg::OP_NONE:  cls.kind = orlb_pkg::K_NONE;
      default:            cls.kind = orlb_pkg::K_NONE;
    endcase
  end

  assign in_stall = (fill_r == orlb_pkg::QCNT_W'(orlb_pkg::QDEPTH));
  assign take     = in_valid && !in_stall;
  assign q_vld    = (fill_r != '0);
  assign q_entry  = slot_r[rd_ptr_r];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (take) begin
      wr_ptr_nxt = (wr_ptr_r == orlb_pkg::QPTR_W'(orlb_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == orlb_pkg::QPTR_W'(orlb_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (take && !q_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (!take && q_pop) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Queue slots
  always_ff @(posedge clk) begin
    if (take) begin
      slot_r[wr_ptr_r] <= cls;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/orlb_back.sv -----
`default_nettype none

module orlb_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_vld,
  input  wire orlb_pkg::entry_t    q_entry,
  output logic                     q_pop,
  output logic                     res_vld,
  output orlb_pkg::result_t        res,
  input  wire logic                res_stall
);

  typedef enum logic [3:0] {
    S_IDLE     = 4'b0001,
    S_RD_WAIT  = 4'b0010,
    S_SCAN_RD  = 4'b0100,
    S_SCAN_CHK = 4'b1000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [orlb_pkg::ADDR_W-1:0]     head_r, head_nxt;
  logic [orlb_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic [orlb_pkg::ADDR_W-1:0]     start_r, start_nxt;
  logic [orlb_pkg::CNT_W-1:0]      cursor_r, cursor_nxt;
  logic [orlb_pkg::LIMIT_W-1:0]    emitted_r, emitted_nxt;
  logic [orlb_pkg::LIMIT_W-1:0]    cap_r, cap_nxt;
  logic                            open_r, open_nxt;
  logic [orlb_pkg::CNT_W-1:0]      skip_r, skip_nxt;
  logic [orlb_pkg::LIMIT_W-1:0]    limit_r, limit_nxt;
  logic                            res_vld_r, res_vld_nxt;
  orlb_pkg::result_t               res_r, res_nxt;

  logic                            ram_we;
  logic [orlb_pkg::ADDR_W-1:0]     ram_waddr;
  logic [orlb_pkg::BYTE_W-1:0]     ram_wdata;
  logic                            ram_re;
  logic [orlb_pkg::ADDR_W-1:0]     ram_raddr;
  logic [orlb_pkg::BYTE_W-1:0]     ram_rdata;

  logic                            can_emit;
  logic                            has_more;
  logic [orlb_pkg::CNT_W-1:0]      cursor_inc;
  logic [orlb_pkg::LIMIT_W-1:0]    emitted_inc;
  logic                            scan_done;
  logic [orlb_pkg::CNT_W-1:0]      skip_fin;

  orlb_ram #(
    .WIDTH (orlb_pkg::BYTE_W),
    .DEPTH (orlb_pkg::CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign res_vld     = res_vld_r;
  assign res         = res_r;
  assign can_emit    = !res_vld_r || !res_stall;
  assign has_more    = open_r && (cursor_r < count_r) && (emitted_r < cap_r);
  assign cursor_inc  = cursor_r + 1'b1;
  assign emitted_inc = emitted_r + 1'b1;

  // Newline search step: found, or the whole store seen
  always_comb begin
    scan_done = 1'b0;
    skip_fin  = skip_r;
    if (ram_rdata == orlb_pkg::NEWLINE_CODE) begin
      scan_done = 1'b1;
      skip_fin  = skip_r + 1'b1;
    end else if (skip_r == orlb_pkg::CAP_LAST) begin
      scan_done = 1'b1;
      skip_fin  = orlb_pkg::CAP_NO_LINE;
    end
  end

  // Execute one command at a time
  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    start_nxt   = start_r;
    cursor_nxt  = cursor_r;
    emitted_nxt = emitted_r;
    cap_nxt     = cap_r;
    open_nxt    = open_r;
    skip_nxt    = skip_r;
    limit_nxt   = limit_r;
    res_vld_nxt = res_vld_r && res_stall;
    res_nxt     = res_r;
    q_pop       = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = head_r;
    ram_wdata   = q_entry.data;
    ram_re      = 1'b0;
    ram_raddr   = start_r + cursor_r[orlb_pkg::ADDR_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (q_vld && can_emit) begin
          q_pop                = 1'b1;
          res_nxt.out_byte     = '0;
          res_nxt.out_valid    = 1'b0;
          res_nxt.out_last     = 1'b0;
          res_nxt.push_stored  = 1'b0;
          res_nxt.stored_count = count_r;
          unique case (q_entry.kind)
            orlb_pkg::K_STORE: begin
              open_nxt = 1'b0;
              ram_we   = 1'b1;
              head_nxt = head_r + 1'b1;
              if (count_r != orlb_pkg::CAP_CNT) begin
                count_nxt = count_r + 1'b1;
              end
              res_nxt.push_stored  = 1'b1;
              res_nxt.stored_count = count_nxt;
              res_vld_nxt          = 1'b1;
            end
            orlb_pkg::K_DROP: begin
              open_nxt    = 1'b0;
              res_vld_nxt = 1'b1;
            end
            orlb_pkg::K_BEGIN: begin
              start_nxt = head_r - count_r[orlb_pkg::ADDR_W-1:0];
              limit_nxt = q_entry.limit;
              if (count_r == orlb_pkg::CAP_CNT) begin
                skip_nxt  = '0;
                state_nxt = S_SCAN_RD;
              end else begin
                cursor_nxt       = '0;
                emitted_nxt      = '0;
                cap_nxt          = q_entry.limit;
                open_nxt         = 1'b1;
                res_nxt.out_last = (count_r == '0) || (q_entry.limit == '0);
                res_vld_nxt      = 1'b1;
              end
            end
            orlb_pkg::K_READ: begin
              if (has_more) begin
                ram_re    = 1'b1;
                state_nxt = S_RD_WAIT;
              end else begin
                res_nxt.out_last = 1'b1;
                res_vld_nxt      = 1'b1;
              end
            end
            orlb_pkg::K_NONE: begin
              res_vld_nxt = 1'b1;
            end
            default: begin
              res_vld_nxt = 1'b1;
            end
          endcase
        end
      end

      // Return the fetched byte and advance the dump
      S_RD_WAIT: begin
        if (can_emit) begin
          cursor_nxt           = cursor_inc;
          emitted_nxt          = emitted_inc;
          res_nxt.out_byte     = ram_rdata;
          res_nxt.out_valid    = 1'b1;
          res_nxt.out_last     = !((cursor_inc < count_r) && (emitted_inc < cap_r));
          res_nxt.push_stored  = 1'b0;
          res_nxt.stored_count = count_r;
          res_vld_nxt          = 1'b1;
          state_nxt            = S_IDLE;
        end
      end

      S_SCAN_RD: begin
        ram_re    = 1'b1;
        ram_raddr = start_r + skip_r[orlb_pkg::ADDR_W-1:0];
        state_nxt = S_SCAN_CHK;
      end

      // Check one byte; open the dump once the first line end is found or the whole store is seen
      S_SCAN_CHK: begin
        if (!scan_done) begin
          skip_nxt  = skip_r + 1'b1;
          state_nxt = S_SCAN_RD;
        end else if (can_emit) begin
          cursor_nxt           = skip_fin;
          emitted_nxt          = '0;
          cap_nxt              = limit_r;
          open_nxt             = 1'b1;
          res_nxt.out_byte     = '0;
          res_nxt.out_valid    = 1'b0;
          res_nxt.out_last     = !((skip_fin < count_r) && (limit_r != '0));
          res_nxt.push_stored  = 1'b0;
          res_nxt.stored_count = count_r;
          res_vld_nxt          = 1'b1;
          state_nxt            = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      head_r    <= '0;
      count_r   <= '0;
      start_r   <= '0;
      cursor_r  <= '0;
      emitted_r <= '0;
      cap_r     <= '0;
      open_r    <= 1'b0;
      skip_r    <= '0;
      res_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      count_r   <= count_nxt;
      start_r   <= start_nxt;
      cursor_r  <= cursor_nxt;
      emitted_r <= emitted_nxt;
      cap_r     <= cap_nxt;
      open_r    <= open_nxt;
      skip_r    <= skip_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    limit_r <= limit_nxt;
    res_r   <= res_nxt;
  end

endmodule

`default_nettype wire

// ----- hdl/overwrite_ring_log_buffer.sv -----
// Path: a taken word waits in a queue slot, then its result is registered (push, begin on a store
//   that is not full, read with nothing left); a byte read also passes the store read register.
// Throughput: one word per cycle while out_stall is low; a byte read blocks later words until
//   its byte returns (one read port). A full-store begin scans up to 4096 bytes for a line end.
// Reset (rst_n low, synchronous): counts, pointers and dump state clear, threshold goes to 7;
//   the byte store keeps its contents and needs no clearing pass.
`default_nettype none

module overwrite_ring_log_buffer (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [orlb_pkg::OP_W-1:0]       in_operation,
  input  wire logic [orlb_pkg::BYTE_W-1:0]     in_data_byte,
  input  wire logic [orlb_pkg::LEVEL_W-1:0]    in_severity,
  input  wire logic [orlb_pkg::LIMIT_W-1:0]    in_dump_limit,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [orlb_pkg::BYTE_W-1:0]          out_out_byte,
  output logic                                 out_out_valid,
  output logic                                 out_out_last,
  output logic                                 out_push_stored,
  output logic [orlb_pkg::CNT_W-1:0]           out_stored_count,
  input  wire logic                            cfg_wr_en,
  input  wire logic [orlb_pkg::LEVEL_W-1:0]    cfg_wr_data
);

  logic              q_vld;
  orlb_pkg::entry_t  q_entry;
  logic              q_pop;
  orlb_pkg::result_t res;

  orlb_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_data_byte  (in_data_byte),
    .in_severity   (in_severity),
    .in_dump_limit (in_dump_limit),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .q_vld         (q_vld),
    .q_entry       (q_entry),
    .q_pop         (q_pop)
  );

  orlb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_vld     (q_vld),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .res_vld   (out_valid),
    .res       (res),
    .res_stall (out_stall)
  );

  // Unpack result word
  assign out_out_byte     = res.out_byte;
  assign out_out_valid    = res.out_valid;
  assign out_out_last     = res.out_last;
  assign out_push_stored  = res.push_stored;
  assign out_stored_count = res.stored_count;

endmodule

`default_nettype wire
